@@ sv/gpdc_pkg.sv @@
// gpdc_pkg: shared types and constants of the gear and pedal drive command block
// used by gpdc_divider, gpdc_gear and gear_pedal_drive_command
// no dependencies
`default_nettype none

package gpdc_pkg;

    // field widths
    localparam int unsigned PEDAL_W   = 8;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned GEAR_W    = 3;
    localparam int unsigned PULSE_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned S_DATA_W  = 24;
    localparam int unsigned M_DATA_W  = 32;

    // shared multiplier and divider widths
    localparam int unsigned MUL_A_W  = 16;
    localparam int unsigned MUL_B_W  = 7;
    localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned QUOT_W   = 16;

    // reciprocal division: quotient = (numerator * reciprocal) >> shift
    // by full scale: numerators below 2^15, divisor below 2^8, shift 23
    // by one hundred: numerators below 2^23, reciprocal error 76, shift 30
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned RPROD_W     = PROD_W + RECIP_W;
    localparam int unsigned SHIFT_SCALE = 23;
    localparam int unsigned SHIFT_PCT   = 30;
    localparam logic [RECIP_W-1:0] RECIP_PCT = 24'd10737419;

    // default pedal full scale
    localparam int unsigned PEDAL_FS_DEFAULT = 64;

    // percent scale
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // gear codes
    localparam logic [GEAR_W-1:0] GEAR_REVERSE = 3'd0;
    localparam logic [GEAR_W-1:0] GEAR_STOP    = 3'd1;
    localparam logic [GEAR_W-1:0] GEAR_FIRST   = 3'd2;
    localparam logic [GEAR_W-1:0] GEAR_SECOND  = 3'd3;
    localparam logic [GEAR_W-1:0] GEAR_THIRD   = 3'd4;
    localparam logic [GEAR_W-1:0] GEAR_TOP     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_THRESH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_PCT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR1_PCT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR2_PCT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR3_PCT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR4_PCT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_FULL     = 3'd6;

    // configuration reset values
    localparam logic [PEDAL_W-1:0] RST_BRAKE_THRESH = 8'd20;
    localparam logic [PCT_W-1:0]   RST_REVERSE_PCT  = 7'd75;
    localparam logic [PCT_W-1:0]   RST_GEAR1_PCT    = 7'd25;
    localparam logic [PCT_W-1:0]   RST_GEAR2_PCT    = 7'd50;
    localparam logic [PCT_W-1:0]   RST_GEAR3_PCT    = 7'd75;
    localparam logic [PCT_W-1:0]   RST_GEAR4_PCT    = 7'd100;
    localparam logic [PULSE_W-1:0] RST_PWM_FULL     = 16'd65535;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic              by_scale;
        logic [PROD_W-1:0] numer;
    } div_req_t;

    // answer from the shared divider
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    // gear stepping control
    typedef struct packed {
        logic update;
        logic up;
        logic down;
    } gear_ctl_t;

endpackage

`default_nettype wire

@@ sv/gpdc_divider.sv @@
// gpdc_divider: division by the pedal full scale or by one hundred through
// reciprocal multiplication, quotient registered in the cycle after the start
// depends on gpdc_pkg
`default_nettype none

module gpdc_divider #(
    parameter int unsigned PEDAL_FULL_SCALE = gpdc_pkg::PEDAL_FS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gpdc_pkg::div_req_t req,
    output gpdc_pkg::div_rsp_t      rsp
);

    localparam longint unsigned FS_DIV = (PEDAL_FULL_SCALE == 0) ? 1 : PEDAL_FULL_SCALE;
    // reciprocal of the full scale rounded up; a zero full scale maps to zero
    localparam logic [gpdc_pkg::RECIP_W-1:0] RECIP_SCALE = (PEDAL_FULL_SCALE == 0) ? '0 :
        gpdc_pkg::RECIP_W'(((64'd1 << gpdc_pkg::SHIFT_SCALE) + FS_DIV - 1) / FS_DIV);

    logic [gpdc_pkg::RECIP_W-1:0] recip;
    logic [gpdc_pkg::RPROD_W-1:0] rprod;
    logic [gpdc_pkg::QUOT_W-1:0]  quot_next;
    logic [gpdc_pkg::QUOT_W-1:0]  quot_reg;
    logic                         done_reg;

    always_comb begin
        recip = req.by_scale ? RECIP_SCALE : gpdc_pkg::RECIP_PCT;
        rprod = gpdc_pkg::RPROD_W'(req.numer) * gpdc_pkg::RPROD_W'(recip);
        if (req.by_scale) begin
            quot_next = rprod[gpdc_pkg::SHIFT_SCALE +: gpdc_pkg::QUOT_W];
        end else begin
            quot_next = rprod[gpdc_pkg::SHIFT_PCT +: gpdc_pkg::QUOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= req.start;
            if (req.start) begin
                quot_reg <= quot_next;
            end
        end
    end

    assign rsp = {done_reg, quot_reg};

endmodule

`default_nettype wire

@@ sv/gpdc_gear.sv @@
// gpdc_gear: gear register stepped by rising edges of the up and down buttons
// up applied first (saturates at top gear), then down (clamps at reverse)
// depends on gpdc_pkg
`default_nettype none

module gpdc_gear (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire gpdc_pkg::gear_ctl_t          ctl,
    output logic [gpdc_pkg::GEAR_W-1:0]       gear
);

    logic [gpdc_pkg::GEAR_W-1:0] gear_reg;
    logic [gpdc_pkg::GEAR_W-1:0] gear_next;
    logic                        up_was_reg;
    logic                        down_was_reg;
    logic [gpdc_pkg::GEAR_W-1:0] g_sat;
    logic [gpdc_pkg::GEAR_W-1:0] g_up;

    always_comb begin
        g_sat = (gear_reg > gpdc_pkg::GEAR_TOP) ? gpdc_pkg::GEAR_TOP : gear_reg;
        g_up  = g_sat;
        if (ctl.up && !up_was_reg) begin
            g_up = (g_sat >= gpdc_pkg::GEAR_TOP) ? gpdc_pkg::GEAR_TOP : g_sat + 1'b1;
        end
        gear_next = g_up;
        if (ctl.down && !down_was_reg) begin
            gear_next = (g_up == gpdc_pkg::GEAR_REVERSE) ? gpdc_pkg::GEAR_REVERSE
                                                          : g_up - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gear_reg     <= gpdc_pkg::GEAR_STOP;
            up_was_reg   <= 1'b0;
            down_was_reg <= 1'b0;
        end else if (ctl.update) begin
            gear_reg     <= gear_next;
            up_was_reg   <= ctl.up;
            down_was_reg <= ctl.down;
        end
    end

    assign gear = gear_reg;

endmodule

`default_nettype wire

@@ sv/gear_pedal_drive_command.sv @@
// gear_pedal_drive_command: top level of the gear and pedal drive command block
// sequencer, shared multiplier and configuration registers
// depends on gpdc_pkg, gpdc_divider, gpdc_gear
//
// usage
//   s_ channel: one transfer per remote-control frame (gas, brake, two buttons)
//   m_ channel: one transfer per frame with gear, direction, duty, pulse, brake light
//   cfg_ port: plain register writes, only while the block is idle
// timing
//   the result is valid once the sequencer has run its steps: the accepting
//   cycle, four products on the shared multiplier, each followed by a reciprocal
//   division, and the output load; the next frame is taken only after that,
//   so the block works on one frame at a time
//   s_tready is high only while the sequencer is idle
// reset
//   synchronous, active low: gear back to stop, button history cleared,
//   configuration registers back to their defaults, output empty
// back-pressure
//   the result waits in an output register; a new frame may be taken while it
//   waits, and its own result is held back until the old one has gone
`default_nettype none

module gear_pedal_drive_command #(
    parameter int unsigned PEDAL_FULL_SCALE = gpdc_pkg::PEDAL_FS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input frame
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // gas_pedal[7:0], brake_pedal[15:8], gear_up_button[16], gear_down_button[17]
    input  wire logic [gpdc_pkg::S_DATA_W-1:0]      s_tdata,
    // drive command
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // gear[2:0], reverse_dir[3], duty_percent[10:4], pwm_pulse[26:11], brake_light[27]
    output logic [gpdc_pkg::M_DATA_W-1:0]           m_tdata,
    // configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [gpdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gpdc_pkg::CFG_DAT_W-1:0]     cfg_data
);

    localparam logic [gpdc_pkg::PEDAL_W-1:0] FULL_SCALE =
        gpdc_pkg::PEDAL_W'(PEDAL_FULL_SCALE);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAS_MUL,
        ST_GAS_DIV,
        ST_BRK_MUL,
        ST_BRK_DIV,
        ST_DUTY_MUL,
        ST_DUTY_DIV,
        ST_PULSE_MUL,
        ST_PULSE_DIV,
        ST_DONE
    } state_t;

    // configuration registers
    logic [gpdc_pkg::PEDAL_W-1:0] brake_thresh_reg;
    logic [gpdc_pkg::PCT_W-1:0]   reverse_pct_reg;
    logic [gpdc_pkg::PCT_W-1:0]   gear1_pct_reg;
    logic [gpdc_pkg::PCT_W-1:0]   gear2_pct_reg;
    logic [gpdc_pkg::PCT_W-1:0]   gear3_pct_reg;
    logic [gpdc_pkg::PCT_W-1:0]   gear4_pct_reg;
    logic [gpdc_pkg::PULSE_W-1:0] pwm_full_reg;

    // sequencer and working registers
    state_t                       state_reg;
    logic [gpdc_pkg::PEDAL_W-1:0] gas_clip_reg;
    logic [gpdc_pkg::PEDAL_W-1:0] brake_clip_reg;
    logic                         force_zero_reg;
    logic                         light_reg;
    logic [gpdc_pkg::PCT_W-1:0]   gm_reg;
    logic [gpdc_pkg::PCT_W-1:0]   bm_reg;
    logic [gpdc_pkg::PCT_W-1:0]   duty_reg;
    logic [gpdc_pkg::PROD_W-1:0]  prod_reg;
    logic                         start_reg;
    logic                         m_tvalid_reg;
    logic [gpdc_pkg::M_DATA_W-1:0] m_tdata_reg;

    // input fields
    logic [gpdc_pkg::PEDAL_W-1:0] in_gas;
    logic [gpdc_pkg::PEDAL_W-1:0] in_brake;
    logic                         in_up;
    logic                         in_down;
    logic                         accept;

    // datapath signals
    logic [gpdc_pkg::GEAR_W-1:0]  gear;
    logic [gpdc_pkg::PCT_W-1:0]   pct_raw;
    logic [gpdc_pkg::PCT_W-1:0]   pct;
    logic [gpdc_pkg::PCT_W-1:0]   pedal;
    logic [gpdc_pkg::MUL_A_W-1:0] mul_a;
    logic [gpdc_pkg::MUL_B_W-1:0] mul_b;
    logic [gpdc_pkg::PROD_W-1:0]  mul_p;
    logic                         out_free;

    gpdc_pkg::div_req_t  div_req;
    gpdc_pkg::div_rsp_t  div_rsp;
    gpdc_pkg::gear_ctl_t gear_ctl;

    assign in_gas   = s_tdata[7:0];
    assign in_brake = s_tdata[15:8];
    assign in_up    = s_tdata[16];
    assign in_down  = s_tdata[17];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // gear steps on the frame's own transfer
    assign gear_ctl.update = accept;
    assign gear_ctl.up     = in_up;
    assign gear_ctl.down   = in_down;

    gpdc_gear u_gear (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (gear_ctl),
        .gear    (gear)
    );

    // percentage of the current gear (zero in stop), values above 100 used as 100
    always_comb begin
        unique case (gear)
            gpdc_pkg::GEAR_REVERSE: pct_raw = reverse_pct_reg;
            gpdc_pkg::GEAR_FIRST:   pct_raw = gear1_pct_reg;
            gpdc_pkg::GEAR_SECOND:  pct_raw = gear2_pct_reg;
            gpdc_pkg::GEAR_THIRD:   pct_raw = gear3_pct_reg;
            gpdc_pkg::GEAR_TOP:     pct_raw = gear4_pct_reg;
            default:                pct_raw = '0;
        endcase
        pct = (pct_raw > gpdc_pkg::PCT_MAX) ? gpdc_pkg::PCT_MAX : pct_raw;
    end

    // pedal value: difference of mapped pedals, zero when brake equals full scale or gas is zero with brake below it
    always_comb begin
        if (force_zero_reg) begin
            pedal = '0;
        end else if (gm_reg > bm_reg) begin
            pedal = gm_reg - bm_reg;
        end else begin
            pedal = bm_reg - gm_reg;
        end
    end

    // shared multiplier operands
    always_comb begin
        unique case (state_reg)
            ST_GAS_MUL: begin
                mul_a = {8'd0, gas_clip_reg};
                mul_b = gpdc_pkg::PCT_MAX;
            end
            ST_BRK_MUL: begin
                mul_a = {8'd0, brake_clip_reg};
                mul_b = gpdc_pkg::PCT_MAX;
            end
            ST_DUTY_MUL: begin
                mul_a = {9'd0, pct};
                mul_b = pedal;
            end
            ST_PULSE_MUL: begin
                mul_a = pwm_full_reg;
                mul_b = duty_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = gpdc_pkg::PROD_W'(mul_a) * gpdc_pkg::PROD_W'(mul_b);
    end

    // pedal mapping divides by full scale, the rest by one hundred
    assign div_req.start    = start_reg;
    assign div_req.by_scale = (state_reg == ST_GAS_DIV) || (state_reg == ST_BRK_DIV);
    assign div_req.numer    = prod_reg;

    gpdc_divider #(
        .PEDAL_FULL_SCALE (PEDAL_FULL_SCALE)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brake_thresh_reg <= gpdc_pkg::RST_BRAKE_THRESH;
            reverse_pct_reg  <= gpdc_pkg::RST_REVERSE_PCT;
            gear1_pct_reg    <= gpdc_pkg::RST_GEAR1_PCT;
            gear2_pct_reg    <= gpdc_pkg::RST_GEAR2_PCT;
            gear3_pct_reg    <= gpdc_pkg::RST_GEAR3_PCT;
            gear4_pct_reg    <= gpdc_pkg::RST_GEAR4_PCT;
            pwm_full_reg     <= gpdc_pkg::RST_PWM_FULL;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gpdc_pkg::CFG_BRAKE_THRESH: brake_thresh_reg <= cfg_data[7:0];
                gpdc_pkg::CFG_REVERSE_PCT:  reverse_pct_reg  <= cfg_data[6:0];
                gpdc_pkg::CFG_GEAR1_PCT:    gear1_pct_reg    <= cfg_data[6:0];
                gpdc_pkg::CFG_GEAR2_PCT:    gear2_pct_reg    <= cfg_data[6:0];
                gpdc_pkg::CFG_GEAR3_PCT:    gear3_pct_reg    <= cfg_data[6:0];
                gpdc_pkg::CFG_GEAR4_PCT:    gear4_pct_reg    <= cfg_data[6:0];
                gpdc_pkg::CFG_PWM_FULL:     pwm_full_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer with output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // divider starts the cycle after each product is taken
            start_reg <= (state_reg == ST_GAS_MUL) || (state_reg == ST_BRK_MUL)
                         || (state_reg == ST_DUTY_MUL) || (state_reg == ST_PULSE_MUL);
            // in the done state the output register is reloaded instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        gas_clip_reg   <= (in_gas > FULL_SCALE) ? FULL_SCALE : in_gas;
                        brake_clip_reg <= (in_brake > FULL_SCALE) ? FULL_SCALE : in_brake;
                        force_zero_reg <= ((in_brake < FULL_SCALE) && (in_gas == '0))
                                          || (in_brake == FULL_SCALE);
                        light_reg      <= (in_brake > brake_thresh_reg);
                        state_reg      <= ST_GAS_MUL;
                    end
                end
                ST_GAS_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_GAS_DIV;
                end
                ST_GAS_DIV: begin
                    if (div_rsp.done) begin
                        gm_reg    <= div_rsp.quot[gpdc_pkg::PCT_W-1:0];
                        state_reg <= ST_BRK_MUL;
                    end
                end
                ST_BRK_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_BRK_DIV;
                end
                ST_BRK_DIV: begin
                    if (div_rsp.done) begin
                        bm_reg    <= div_rsp.quot[gpdc_pkg::PCT_W-1:0];
                        state_reg <= ST_DUTY_MUL;
                    end
                end
                ST_DUTY_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_DUTY_DIV;
                end
                ST_DUTY_DIV: begin
                    if (div_rsp.done) begin
                        duty_reg  <= div_rsp.quot[gpdc_pkg::PCT_W-1:0];
                        state_reg <= ST_PULSE_MUL;
                    end
                end
                ST_PULSE_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_PULSE_DIV;
                end
                ST_PULSE_DIV: begin
                    if (div_rsp.done) begin
                        prod_reg  <= {7'd0, div_rsp.quot};
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the previous result has been taken
                    if (out_free) begin
                        m_tdata_reg  <= {4'd0, light_reg,
                                         prod_reg[gpdc_pkg::PULSE_W-1:0], duty_reg,
                                         (gear == gpdc_pkg::GEAR_REVERSE), gear};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
